// ===== hdl/u8gl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8gl_pkg
// Types, constants and decode helpers shared by the UTF-8 glyph layout block.
// ----------------------------------------------------------------------------
package u8gl_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_GLYPH_CAPACITY   = 8'd0;
  localparam logic [7:0] REG_REPLACEMENT_CODE = 8'd1;

  localparam logic [31:0] GLYPH_CAPACITY_RESET   = 32'hFFFF_FFFF;
  localparam logic [20:0] REPLACEMENT_CODE_RESET = 21'h00_FFFD;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // lead byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;

  // sequence lengths; zero marks a bad lead
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  // code points from here on take two cells
  localparam logic [20:0] WIDE_START = 21'h00_1100;

  // one decoded glyph
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
  } rec_t;

  // all glyphs caused by one input beat
  typedef struct packed {
    logic [1:0]      count;       // 1..3
    logic            final_flag;
    rec_t [2:0]      recs;
  } group_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
  } queue_stat_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] k;
    if (b < ASCII_LIMIT)                     k = LEN_1;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) k = LEN_2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) k = LEN_3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) k = LEN_4;
    else                                     k = LEN_BAD;
    return k;
  endfunction

  // decode at pos of seq[0..n-1]; a sequence that does not fit gives rep
  function automatic rec_t decode_at(input logic [3:0][7:0] seq, input logic [2:0] n,
                                     input logic [2:0] pos, input logic [20:0] rep);
    logic [7:0] b0, b1, b2, b3;
    logic [2:0] avail;
    logic [2:0] k;
    rec_t       r;
    b0    = seq[pos[1:0]];
    b1    = seq[pos[1:0] + 2'd1];
    b2    = seq[pos[1:0] + 2'd2];
    b3    = seq[pos[1:0] + 2'd3];
    avail = n - pos;
    k     = lead_length(b0);
    r.cp  = rep;
    r.len = LEN_1;
    case (k)
      LEN_1: begin
        r.cp = {13'd0, b0};
      end
      LEN_2: begin
        if (avail >= LEN_2) begin
          r.cp  = {10'd0, b0[4:0], b1[5:0]};
          r.len = LEN_2;
        end
      end
      LEN_3: begin
        if (avail >= LEN_3) begin
          r.cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
          r.len = LEN_3;
        end
      end
      LEN_4: begin
        if (avail >= LEN_4) begin
          r.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
          r.len = LEN_4;
        end
      end
      default: begin
        r.cp  = rep;
        r.len = LEN_1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/u8gl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8gl_if
// Valid/ready channels: raw text bytes in, glyph records out.
// ----------------------------------------------------------------------------
interface u8gl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface u8gl_glyph_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [31:0] start_offset;
  logic [2:0]  seq_bytes;
  logic [1:0]  cell_count;
  logic [4:0]  pixel_span;
  logic [31:0] glyph_index;
  logic        slot_stored;
  logic [32:0] cells_so_far;
  logic [35:0] pixels_so_far;
  logic        run_end;
  logic        text_end;

  modport source (output valid, code_point, start_offset, seq_bytes, cell_count,
                  pixel_span, glyph_index, slot_stored, cells_so_far,
                  pixels_so_far, run_end, text_end, input ready);
  modport sink   (input valid, code_point, start_offset, seq_bytes, cell_count,
                  pixel_span, glyph_index, slot_stored, cells_so_far,
                  pixels_so_far, run_end, text_end, output ready);
endinterface

// ===== hdl/u8gl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8gl_front
// Takes text bytes, keeps partial sequences and decodes them into groups of
// one to three glyphs that go to the queue.
// ----------------------------------------------------------------------------
module u8gl_front (
  input  logic                  clk,
  input  logic                  rst,
  u8gl_byte_if.sink             text,
  input  logic [20:0]           replacement_code,
  input  u8gl_pkg::queue_stat_t stat,
  output logic                  push,
  output u8gl_pkg::group_t      push_data
);
  import u8gl_pkg::*;

  logic [2:0][7:0] held_bytes;
  logic [1:0]      held_count;

  logic [3:0][7:0] seq;
  logic [2:0]      n;
  logic [2:0]      k;
  logic            accept;
  logic            emit;
  rec_t            r0, r1, r2;
  logic [2:0]      pos1, pos2;
  logic            v1, v2;

  assign text.ready = !stat.full;
  assign accept     = text.valid && text.ready;

  // held bytes followed by the new byte
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j < 3 && 2'(j) != held_count) seq[j] = held_bytes[j];
      else                              seq[j] = text.text_byte;
    end
  end

  assign n = {1'b0, held_count} + 3'd1;
  assign k = lead_length(seq[0]);

  // up to three decodes, each starting where the one before ended
  assign r0   = decode_at(seq, n, 3'd0, replacement_code);
  assign pos1 = r0.len;
  assign v1   = pos1 < n;
  assign r1   = decode_at(seq, n, pos1, replacement_code);
  assign pos2 = pos1 + r1.len;
  assign v2   = v1 && (pos2 < n);
  assign r2   = decode_at(seq, n, pos2, replacement_code);

  // a sequence that is not yet complete is only held
  assign emit = text.final_byte || (k <= LEN_1) || (n >= k);
  assign push = accept && emit;

  always_comb begin
    push_data.final_flag = text.final_byte;
    push_data.recs[0]    = r0;
    push_data.recs[1]    = r1;
    push_data.recs[2]    = r2;
    if (text.final_byte) push_data.count = 2'd1 + {1'b0, v1} + {1'b0, v2};
    else                 push_data.count = 2'd1;
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      if (emit) held_count <= 2'd0;
      else      held_count <= n[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emit && held_count != 2'd3) begin
      held_bytes[held_count] <= text.text_byte;
    end
  end

endmodule

// ===== hdl/u8gl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8gl_queue
// Short FIFO of glyph groups between the decoding front and the layout back.
// ----------------------------------------------------------------------------
module u8gl_queue #(
  parameter int DEPTH = u8gl_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8gl_pkg::group_t      push_data,
  output u8gl_pkg::queue_stat_t stat,
  input  logic                  pop,
  output logic                  head_valid,
  output u8gl_pkg::group_t      head_data
);
  import u8gl_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t          mem [DEPTH];
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign stat.full  = fill == CW'(DEPTH);
  assign head_valid = fill != '0;
  assign head_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/u8gl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8gl_back
// Walks each group one glyph per cycle while the receiver is ready, adds
// offsets, indexes and running cell and pixel totals, and holds the result
// in the output register.
module u8gl_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  u8gl_pkg::group_t head_data,
  output logic             pop,
  input  logic [31:0]      glyph_capacity,
  u8gl_glyph_if.source     glyph
);
  import u8gl_pkg::*;

  logic [31:0] byte_position;
  logic [31:0] glyph_counter;
  logic [32:0] cell_total;
  logic [35:0] pixel_total;
  logic [1:0]  sub;

  rec_t        rec;
  logic        advance;
  logic        load;
  logic        last;
  logic        text_done;
  logic [1:0]  cells;
  logic [4:0]  pixels;
  logic [32:0] cell_total_next;
  logic [35:0] pixel_total_next;

  assign advance   = !glyph.valid || glyph.ready;
  assign load      = advance && head_valid;
  assign rec       = head_data.recs[sub];
  assign last      = sub == (head_data.count - 2'd1);
  assign text_done = last && head_data.final_flag;
  assign pop       = load && last;

  assign cells            = (rec.cp >= WIDE_START) ? 2'd2 : 2'd1;
  assign pixels           = {cells, 3'b000};
  assign cell_total_next  = cell_total + {31'd0, cells};
  assign pixel_total_next = pixel_total + {31'd0, pixels};

  // position within the group and running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sub           <= 2'd0;
      byte_position <= '0;
      glyph_counter <= '0;
      cell_total    <= '0;
      pixel_total   <= '0;
    end else if (load) begin
      sub <= last ? 2'd0 : sub + 2'd1;
      if (text_done) begin
        byte_position <= '0;
        glyph_counter <= '0;
        cell_total    <= '0;
        pixel_total   <= '0;
      end else begin
        byte_position <= byte_position + {29'd0, rec.len};
        glyph_counter <= glyph_counter + 32'd1;
        cell_total    <= cell_total_next;
        pixel_total   <= pixel_total_next;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst)          glyph.valid <= 1'b0;
    else if (advance) glyph.valid <= head_valid;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      glyph.code_point    <= rec.cp;
      glyph.start_offset  <= byte_position;
      glyph.seq_bytes     <= rec.len;
      glyph.cell_count    <= cells;
      glyph.pixel_span    <= pixels;
      glyph.glyph_index   <= glyph_counter;
      glyph.slot_stored   <= glyph_counter < glyph_capacity;
      glyph.cells_so_far  <= cell_total_next;
      glyph.pixels_so_far <= pixel_total_next;
      glyph.run_end       <= last;
      glyph.text_end      <= text_done;
    end
  end

endmodule

// ===== hdl/utf8_glyph_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_glyph_layout
// Streaming UTF-8 decoder that emits one layout record per code point.
// ----------------------------------------------------------------------------
// Usage:
//   text  : one byte per beat, final_byte set on the last byte of a text.
//   glyph : one record per code point, with offset, length, cell and pixel
//           width, glyph index, stored flag and running totals. run_end
//           marks the last record of an input byte, text_end the last one
//           of the text.
//   cfg_* : register writes (glyph capacity, replacement code); the user must
//           make them only while idle, the block does not enforce this.
// A byte that completes a glyph goes through the queue and the output register.
// Throughput: one byte per cycle while the queue is not full. Records leave
//   at one per cycle from the back end while the receiver is ready, so
//   a final byte that closes a truncated sequence (up to three records)
//   holds the back end while they leave; the queue in front absorbs that.
// Reset clears held bytes, counters, queue and output, and loads the
// register defaults. When the receiver stalls the record is held, the queue
// fills and text.ready drops once it is full.
// ----------------------------------------------------------------------------
module utf8_glyph_layout #(
  parameter int QUEUE_DEPTH = u8gl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  u8gl_byte_if.sink    text,
  u8gl_glyph_if.source glyph
);
  import u8gl_pkg::*;

  logic [31:0] glyph_capacity;
  logic [20:0] replacement_code;
  logic        push;
  group_t      push_data;
  queue_stat_t stat;
  logic        pop;
  logic        head_valid;
  group_t      head_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_capacity   <= GLYPH_CAPACITY_RESET;
      replacement_code <= REPLACEMENT_CODE_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == REG_GLYPH_CAPACITY)   glyph_capacity   <= cfg_wdata;
      if (cfg_index == REG_REPLACEMENT_CODE) replacement_code <= cfg_wdata[20:0];
    end
  end

  u8gl_front u_front (
    .clk              (clk),
    .rst              (rst),
    .text             (text),
    .replacement_code (replacement_code),
    .stat             (stat),
    .push             (push),
    .push_data        (push_data)
  );

  u8gl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .stat       (stat),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  u8gl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .glyph_capacity (glyph_capacity),
    .glyph          (glyph)
  );

endmodule

// ===== verif/utf8_glyph_layout_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_glyph_layout_checker
// Watches the text and glyph channels and the register port, predicts every
// glyph record from the accepted bytes and compares each record field by
// field, in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module utf8_glyph_layout_checker
  import u8gl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  u8gl_byte_if        text,
  u8gl_glyph_if       glyph,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [20:0] code_point;
    logic [31:0] start_offset;
    logic [2:0]  seq_bytes;
    logic [1:0]  cell_count;
    logic [4:0]  pixel_span;
    logic [31:0] glyph_index;
    logic        slot_stored;
    logic [32:0] cells_so_far;
    logic [35:0] pixels_so_far;
    logic        run_end;
    logic        text_end;
  } glyph_rec_t;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
  } decoded_t;

  // register copies
  logic [31:0]     capacity;
  logic [20:0]     rep_code;

  // decoder and layout state
  logic [2:0][7:0] held;
  int              held_n;
  logic [31:0]     byte_pos;
  logic [31:0]     glyph_idx;
  logic [32:0]     cell_sum;
  logic [35:0]     pixel_sum;

  glyph_rec_t      layout_q[$];
  glyph_rec_t      want;
  int              mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [2:0] seq_len_of(input logic [7:0] lead);
    casez (lead)
      8'b0???????: return LEN_1;
      8'b110?????: return LEN_2;
      8'b1110????: return LEN_3;
      8'b11110???: return LEN_4;
      default:     return LEN_BAD;
    endcase
  endfunction

  // a sequence running past the n bytes on hand decodes as the replacement
  function automatic decoded_t decode_glyph(input logic [3:0][7:0] seq, input int n,
                                            input int pos);
    decoded_t   d;
    logic [2:0] k;
    k     = seq_len_of(seq[pos]);
    d.cp  = rep_code;
    d.len = LEN_1;
    if (k == LEN_1) begin
      d.cp = {13'd0, seq[pos]};
    end else if (k != LEN_BAD && pos + int'(k) <= n) begin
      d.len = k;
      case (k)
        LEN_2:   d.cp = {10'd0, seq[pos][4:0], seq[pos+1][5:0]};
        LEN_3:   d.cp = {5'd0, seq[pos][3:0], seq[pos+1][5:0], seq[pos+2][5:0]};
        default: d.cp = {seq[pos][2:0], seq[pos+1][5:0], seq[pos+2][5:0],
                         seq[pos+3][5:0]};
      endcase
    end
    return d;
  endfunction

  // lay out one glyph and advance the running counters
  function automatic glyph_rec_t place_glyph(input decoded_t d);
    glyph_rec_t r;
    logic [1:0] cells;
    cells           = (d.cp >= WIDE_START) ? 2'd2 : 2'd1;
    cell_sum        = cell_sum + cells;
    pixel_sum       = pixel_sum + {cells, 3'b000};
    r.code_point    = d.cp;
    r.start_offset  = byte_pos;
    r.seq_bytes     = d.len;
    r.cell_count    = cells;
    r.pixel_span    = {cells, 3'b000};
    r.glyph_index   = glyph_idx;
    r.slot_stored   = glyph_idx < capacity;
    r.cells_so_far  = cell_sum;
    r.pixels_so_far = pixel_sum;
    r.run_end       = 1'b0;
    r.text_end      = 1'b0;
    byte_pos        = byte_pos + d.len;
    glyph_idx       = glyph_idx + 1;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] seq;
    glyph_rec_t      recs [3];
    decoded_t        d;
    logic [2:0]      lead_len;
    int              n;
    int              pos;
    int              cnt;
    seq = '0;
    for (int i = 0; i < held_n; i++) seq[i] = held[i];
    seq[held_n] = b;
    n        = held_n + 1;
    lead_len = seq_len_of(seq[0]);
    pos      = 0;
    cnt      = 0;
    if (fin) begin
      // text ends here: a cut-off lead gives the replacement, the bytes
      // behind it are decoded again as leads
      while (pos < n && cnt < 3) begin
        d         = decode_glyph(seq, n, pos);
        recs[cnt] = place_glyph(d);
        cnt++;
        pos += int'(d.len);
      end
    end else if (lead_len <= LEN_1 || n >= int'(lead_len)) begin
      d       = decode_glyph(seq, n, 0);
      recs[0] = place_glyph(d);
      cnt     = 1;
      pos     = int'(d.len);
    end

    // sequence still open: keep its bytes
    if (!fin && pos < n && n <= 3) begin
      for (int i = 0; i < 3; i++) held[i] = seq[i];
      held_n = n;
    end else begin
      held_n = 0;
    end

    if (cnt > 0) begin
      recs[cnt-1].run_end  = 1'b1;
      recs[cnt-1].text_end = fin;
    end
    for (int i = 0; i < cnt; i++) layout_q.push_back(recs[i]);

    if (fin) begin
      byte_pos  = '0;
      glyph_idx = '0;
      cell_sum  = '0;
      pixel_sum = '0;
    end
  endtask

  function automatic void check_field(input string name, input logic [35:0] exp_val,
                                      input logic [35:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      capacity  = GLYPH_CAPACITY_RESET;
      rep_code  = REPLACEMENT_CODE_RESET;
      held      = '0;
      held_n    = 0;
      byte_pos  = '0;
      glyph_idx = '0;
      cell_sum  = '0;
      pixel_sum = '0;
      layout_q.delete();
    end else begin
      // register writes; unknown indexes are ignored
      if (cfg_wen) begin
        case (cfg_index)
          REG_GLYPH_CAPACITY:   capacity = cfg_wdata;
          REG_REPLACEMENT_CODE: rep_code = cfg_wdata[20:0];
          default: ;
        endcase
      end

      // compare an outgoing record before predicting from this edge's byte
      if (glyph.valid && glyph.ready) begin
        if (layout_q.size() == 0) begin
          $error("glyph beat with nothing expected: code_point 0x%0h", glyph.code_point);
          mismatches++;
        end else begin
          want = layout_q.pop_front();
          check_field("code_point", want.code_point, glyph.code_point);
          check_field("start_offset", want.start_offset, glyph.start_offset);
          check_field("seq_bytes", want.seq_bytes, glyph.seq_bytes);
          check_field("cell_count", want.cell_count, glyph.cell_count);
          check_field("pixel_span", want.pixel_span, glyph.pixel_span);
          check_field("glyph_index", want.glyph_index, glyph.glyph_index);
          check_field("slot_stored", want.slot_stored, glyph.slot_stored);
          check_field("cells_so_far", want.cells_so_far, glyph.cells_so_far);
          check_field("pixels_so_far", want.pixels_so_far, glyph.pixels_so_far);
          check_field("run_end", want.run_end, glyph.run_end);
          check_field("text_end", want.text_end, glyph.text_end);
        end
      end

      if (text.valid && text.ready) predict_byte(text.text_byte, text.final_byte);
    end
    pending <= layout_q.size();
  end

endmodule

// ===== verif/utf8_glyph_layout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_glyph_layout_tb
// Drives byte texts into the UTF-8 glyph layout block: a directed run over
// field extremes, bad and cut-off leads, then random texts, mostly well
// formed, under several register settings and idle/stall mixes. The
// checker beside the block predicts and compares every glyph record.
// ----------------------------------------------------------------------------
module utf8_glyph_layout_tb;
  import u8gl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int PHASE_BYTES = 64;
  localparam int SETTLE_CYCLES = 10;

  // {final_byte, text_byte}
  localparam logic [8:0] DIRECTED [23] = '{
    9'h000, 9'h07F,                  // ASCII extremes
    9'h0C2, 9'h0A9,                  // two-byte sequence
    9'h0E1, 9'h084, 9'h080,          // U+1100, first wide code point
    9'h0E1, 9'h083, 9'h0BF,          // U+10FF, last narrow one
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // largest four-byte value
    9'h080, 9'h0FF, 9'h0F8,          // bad leads
    9'h0F0, 9'h041, 9'h142,          // cut-off lead, held bytes decoded again
    9'h1E2,                          // text of a lone cut-off lead
    9'h0E2, 9'h182                   // cut-off lead followed by a bad lead
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wen;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          cycle_count;
  int          fail_count;
  int          pending;
  logic [7:0]  text_q[$];

  u8gl_byte_if  text_if ();
  u8gl_glyph_if glyph_if ();

  always #4 clk = ~clk;

  utf8_glyph_layout u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .text      (text_if),
    .glyph     (glyph_if)
  );

  utf8_glyph_layout_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .text       (text_if),
    .glyph      (glyph_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver stalls
  always @(posedge clk) begin
    glyph_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // run-time guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // one beat; valid stays up between back-to-back beats
  task automatic send_beat(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < src_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.final_byte <= fin;
    do @(posedge clk); while (!text_if.ready);
  endtask

  // drop valid, wait for every record, then let the pipeline empty
  task automatic settle();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, plus a write to an unused index that must be ignored
  task automatic set_phase(input logic [31:0] cap, input logic [20:0] rep,
                           input int src_pct, input int sink_pct);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_GLYPH_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_index <= REG_REPLACEMENT_CODE;
    cfg_wdata <= {11'd0, rep};
    @(posedge clk);
    cfg_index <= 8'($urandom_range(2, 255));
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_wen        <= 1'b0;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // trail byte; now and then a byte that is no continuation at all
  function automatic logic [7:0] trail_byte();
    if ($urandom_range(99) < 8) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] bad_lead();
    if ($urandom_range(1) == 1) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(8'hF8, 8'hFF));
  endfunction

  // an nbytes-long sequence, cut after keep bytes
  function automatic void push_glyph(input int nbytes, input int keep);
    logic [7:0] lead;
    case (nbytes)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    text_q.push_back(lead);
    for (int i = 1; i < keep; i++) text_q.push_back(trail_byte());
  endfunction

  // mostly well-formed glyphs, some bad leads, some texts cut mid-sequence
  function automatic void build_text();
    int len;
    text_q.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(99) < 10) begin
        text_q.push_back(bad_lead());
      end else begin
        len = $urandom_range(1, 4);
        push_glyph(len, len);
      end
    end
    if ($urandom_range(99) < 25) begin
      len = $urandom_range(2, 4);
      push_glyph(len, $urandom_range(1, len - 1));
    end
  endfunction

  task automatic run_phase(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_text();
      foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
      sent += text_q.size();
    end
    settle();
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_wen            <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    text_if.valid      <= 1'b0;
    text_if.text_byte  <= '0;
    text_if.final_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed texts at the reset register values
    foreach (DIRECTED[i]) send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
    settle();

    // random texts under changing registers and idle mixes
    set_phase(32'd0, 21'd0, 0, 0);
    run_phase(PHASE_BYTES);
    set_phase(32'hFFFF_FFFF, 21'h10_FFFF, 65, 0);
    run_phase(PHASE_BYTES);
    set_phase(32'd3, REPLACEMENT_CODE_RESET, 0, 65);
    run_phase(PHASE_BYTES);
    set_phase(32'd1, 21'($urandom_range(0, 21'h10_FFFF)), 28, 28);
    run_phase(PHASE_BYTES);
    set_phase($urandom, 21'($urandom_range(0, 21'h10_FFFF)), 0, 0);
    run_phase(PHASE_BYTES);
    set_phase($urandom_range(2, 6), 21'($urandom_range(0, 21'h10_FFFF)), 28, 28);
    run_phase(PHASE_BYTES);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
